// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DEDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DEDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/dedc_pkg.sv =====
// Shared constants, codes and types of the dictionary expansion decoder.
package dedc_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int EIDX_W     = 16;
    localparam int EOFF_W     = 5;
    localparam int LEN_W      = 6;
    localparam int ERR_W      = 2;

    // Default table geometry
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int ENTRY_BYTES_DEF   = 32;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ESCAPE = 1'b0;
    localparam logic REG_STUFF  = 1'b1;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h00;
    localparam logic [BYTE_W-1:0] STUFF_RST  = 8'h01;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TRUNC    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DANGLING = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd3;

    // Stream parse phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Result of one pass through the unstuff unit
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] value;
        logic              marker_next;
    } unstuff_res_t;

endpackage

// ===== hw/rtl/dedc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dedc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/dedc_unstuff.sv =====
// Shared unstuff unit: one byte in, at most one byte out, marker update.
module dedc_unstuff (
    input  logic [dedc_pkg::BYTE_W-1:0] in_byte,
    input  logic                        marker,
    input  logic [dedc_pkg::BYTE_W-1:0] stuff_code,
    output dedc_pkg::unstuff_res_t      res
);
    import dedc_pkg::*;

    // Resolve a pending marker first, then test for a new one
    always_comb begin
        res = '0;
        if (marker) begin
            res.emit        = 1'b1;
            res.value       = in_byte - BYTE_W'(1);
            res.marker_next = 1'b0;
        end else if (in_byte == stuff_code) begin
            res.emit        = 1'b0;
            res.marker_next = 1'b1;
        end else begin
            res.emit        = 1'b1;
            res.value       = in_byte;
            res.marker_next = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/dictionary_expansion_decoder_top.sv =====
// Top level of the dictionary expansion decoder: sequencer, tables, config.
//
// Usage:
//   The s_ channel takes one item per beat: kind 1 writes one dictionary byte
//   (entry_end sets the entry length), kind 0 is one byte of the encoded stream.
//   The m_ channel returns decoded bytes; run_last marks the last result of an
//   item and error_code rides on that result only; pready is always high. An item
//   that decodes nothing and flags nothing returns no result. Write escape_code
//   (address 0) and stuff_code (address 4) over APB only while idle; not enforced.
// Sequencing:
//   Items are taken one at a time. A table write stays in ST_IDLE; any other
//   stream byte passes ST_FINISH, and the high index byte of an in-range reference
//   first passes ST_LEN, then ST_EXPAND for each entry byte: the entry byte memory
//   has one read port, so the unstuff unit sees one stored byte per cycle unless a
//   parked byte stalls. A decoded byte is parked, then moved to the output register.
// Reset:
//   After aresetn the length table is swept to zero, one entry per cycle, with
//   s_ready low. Entry bytes are not cleared.
// Backpressure:
//   While m_ready is low the output register holds, one decoded byte is parked,
//   and the sequencer waits; no result is dropped.
`include "assert_macros.svh"

module dictionary_expansion_decoder_top #(
    parameter int TABLE_ENTRIES = dedc_pkg::TABLE_ENTRIES_DEF,
    parameter int ENTRY_BYTES   = dedc_pkg::ENTRY_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dedc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dedc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dedc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [dedc_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic [dedc_pkg::EIDX_W-1:0]     s_entry_index,
    input  logic [dedc_pkg::EOFF_W-1:0]     s_entry_offset,
    input  logic                            s_entry_end,
    input  logic                            s_message_end,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [dedc_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                            m_has_byte,
    output logic                            m_run_last,
    output logic [dedc_pkg::ERR_W-1:0]      m_error_code
);
    import dedc_pkg::*;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BDEPTH = TABLE_ENTRIES * ENTRY_BYTES;
    localparam int BA_W   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int K_W    = $clog2(ENTRY_BYTES + 1);
    localparam logic [EIDX_W:0]  TE_LIMIT = (EIDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [EOFF_W+1:0] EB_LIMIT = (EOFF_W + 2)'(ENTRY_BYTES);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(TABLE_ENTRIES - 1);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LEN    = 3'd2;
    localparam logic [2:0] ST_EXPAND = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Configuration registers
    logic [BYTE_W-1:0] escape_reg, escape_next;
    logic [BYTE_W-1:0] stuff_reg, stuff_next;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic             marker_reg, marker_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    // Working payload
    logic [BYTE_W-1:0] low_reg, low_next;
    logic [EIDX_W-1:0] idx_reg, idx_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic              mend_reg, mend_next;
    logic [BYTE_W-1:0] hold_byte_reg, hold_byte_next;
    logic [K_W-1:0]    len_reg, len_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [BA_W-1:0]   base_reg, base_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg, m_byte_next;
    logic              m_has_reg, m_has_next;
    logic              m_last_reg, m_last_next;
    logic [ERR_W-1:0]  m_err_reg, m_err_next;

    // Memory ports
    logic              lram_we;
    logic [IDX_W-1:0]  lram_waddr;
    logic [LEN_W-1:0]  lram_wdata;
    logic [IDX_W-1:0]  lram_raddr;
    logic [LEN_W-1:0]  lram_rdata;
    logic              bram_we;
    logic [BA_W-1:0]   bram_waddr;
    logic [BA_W-1:0]   bram_raddr;
    logic [BYTE_W-1:0] bram_rdata;

    // Misc
    logic              accept;
    logic              cfg_wr;
    logic              wr_in_range;
    logic              out_free;
    logic [BYTE_W-1:0] us_in;
    unstuff_res_t      us_res;
    logic [EIDX_W-1:0] ref_idx;
    logic              ref_in_range;
    logic [K_W-1:0]    eff_len;
    logic [BA_W-1:0]   base_now;
    logic [ERR_W-1:0]  fin_err;
    logic              fin_push;

    // Handshake and APB
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_STUFF) ? APB_DATA_W'(stuff_reg)
                                               : APB_DATA_W'(escape_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        escape_next = escape_reg;
        stuff_next  = stuff_reg;
        if (cfg_wr) begin
            if (paddr[2] == REG_STUFF) begin
                stuff_next = pwdata[BYTE_W-1:0];
            end else begin
                escape_next = pwdata[BYTE_W-1:0];
            end
        end
    end

    // Table writes go straight to the memories on the accepting beat
    assign wr_in_range = ({1'b0, s_entry_index} < TE_LIMIT) &&
                         ({2'b00, s_entry_offset} < EB_LIMIT);
    assign bram_we     = accept && s_kind && wr_in_range;
    assign bram_waddr  = BA_W'(32'(s_entry_index) * 32'(ENTRY_BYTES) + 32'(s_entry_offset));

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            lram_we    = 1'b1;
            lram_waddr = clr_reg;
            lram_wdata = '0;
        end else begin
            lram_we    = bram_we && s_entry_end;
            lram_waddr = s_entry_index[IDX_W-1:0];
            lram_wdata = LEN_W'(s_entry_offset) + LEN_W'(1);
        end
    end

    // Reference index and clamped entry length
    assign ref_idx      = {s_data_byte, low_reg};
    assign ref_in_range = ({1'b0, ref_idx} < TE_LIMIT);
    assign lram_raddr   = ref_idx[IDX_W-1:0];
    assign base_now     = BA_W'(32'(idx_reg) * 32'(ENTRY_BYTES));

    always_comb begin
        if (32'(lram_rdata) > 32'(ENTRY_BYTES)) begin
            eff_len = K_W'(ENTRY_BYTES);
        end else begin
            eff_len = K_W'(lram_rdata);
        end
    end

    // Final error of an item and whether it needs a result
    always_comb begin
        fin_err = err_reg;
        if (err_reg == ERR_NONE && mend_reg && marker_reg) begin
            fin_err = ERR_DANGLING;
        end
        fin_push = hold_valid_reg || (fin_err != ERR_NONE);
    end

    // Shared unstuff unit: stream byte when idle, stored byte when expanding
    assign us_in = (state_reg == ST_EXPAND) ? bram_rdata : s_data_byte;

    dedc_unstuff u_unstuff (
        .in_byte    (us_in),
        .marker     (marker_reg),
        .stuff_code (stuff_reg),
        .res        (us_res)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        marker_next     = marker_reg;
        hold_valid_next = hold_valid_reg;
        clr_next        = clr_reg;
        low_next        = low_reg;
        idx_next        = idx_reg;
        err_next        = err_reg;
        mend_next       = mend_reg;
        hold_byte_next  = hold_byte_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        bram_raddr      = base_reg + BA_W'(k_reg);
        m_valid_next    = m_valid_reg && !m_ready;
        m_byte_next     = m_byte_reg;
        m_has_next      = m_has_reg;
        m_last_next     = m_last_reg;
        m_err_next      = m_err_reg;

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept && !s_kind) begin
                    err_next  = ERR_NONE;
                    mend_next = s_message_end;
                    case (phase_reg)
                        PH_ESC: begin
                            low_next   = s_data_byte;
                            phase_next = PH_LOW;
                            if (s_message_end) begin
                                err_next = ERR_TRUNC;
                            end
                            state_next = ST_FINISH;
                        end
                        PH_LOW: begin
                            idx_next   = ref_idx;
                            phase_next = PH_IDLE;
                            if (ref_in_range) begin
                                state_next = ST_LEN;
                            end else begin
                                err_next   = ERR_RANGE;
                                state_next = ST_FINISH;
                            end
                        end
                        default: begin
                            if (s_data_byte == escape_reg) begin
                                phase_next = PH_ESC;
                                if (s_message_end) begin
                                    err_next = ERR_TRUNC;
                                end
                            end else begin
                                marker_next = us_res.marker_next;
                                if (us_res.emit) begin
                                    hold_valid_next = 1'b1;
                                    hold_byte_next  = us_res.value;
                                end
                            end
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_LEN: begin
                len_next   = eff_len;
                k_next     = '0;
                base_next  = base_now;
                bram_raddr = base_now;
                state_next = (eff_len == '0) ? ST_FINISH : ST_EXPAND;
            end

            ST_EXPAND: begin
                // Stall while a parked byte cannot move out
                if (!(us_res.emit && hold_valid_reg && !out_free)) begin
                    marker_next = us_res.marker_next;
                    if (us_res.emit) begin
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_byte_next  = hold_byte_reg;
                            m_has_next   = 1'b1;
                            m_last_next  = 1'b0;
                            m_err_next   = ERR_NONE;
                        end
                        hold_valid_next = 1'b1;
                        hold_byte_next  = us_res.value;
                    end
                    if (k_reg == len_reg - K_W'(1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        k_next     = k_reg + K_W'(1);
                        bram_raddr = base_reg + BA_W'(k_reg + K_W'(1));
                    end
                end
            end

            ST_FINISH: begin
                // Drain the parked byte with the item's status; close the message at its end
                if (!fin_push || out_free) begin
                    if (fin_push) begin
                        m_valid_next = 1'b1;
                        m_byte_next  = hold_valid_reg ? hold_byte_reg : '0;
                        m_has_next   = hold_valid_reg;
                        m_last_next  = 1'b1;
                        m_err_next   = fin_err;
                    end
                    hold_valid_next = 1'b0;
                    if (mend_reg) begin
                        phase_next  = PH_IDLE;
                        marker_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            phase_reg      <= PH_IDLE;
            marker_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            clr_reg        <= '0;
            m_valid_reg    <= 1'b0;
            escape_reg     <= ESCAPE_RST;
            stuff_reg      <= STUFF_RST;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            marker_reg     <= marker_next;
            hold_valid_reg <= hold_valid_next;
            clr_reg        <= clr_next;
            m_valid_reg    <= m_valid_next;
            escape_reg     <= escape_next;
            stuff_reg      <= stuff_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        low_reg       <= low_next;
        idx_reg       <= idx_next;
        err_reg       <= err_next;
        mend_reg      <= mend_next;
        hold_byte_reg <= hold_byte_next;
        len_reg       <= len_next;
        k_reg         <= k_next;
        base_reg      <= base_next;
        m_byte_reg    <= m_byte_next;
        m_has_reg     <= m_has_next;
        m_last_reg    <= m_last_next;
        m_err_reg     <= m_err_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_has_byte   = m_has_reg;
    assign m_run_last   = m_last_reg;
    assign m_error_code = m_err_reg;

    // Entry length table
    dedc_ram #(
        .WIDTH (LEN_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (lram_we),
        .waddr (lram_waddr),
        .wdata (lram_wdata),
        .raddr (lram_raddr),
        .rdata (lram_rdata)
    );

    // Entry byte store
    dedc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BDEPTH)
    ) u_byte_ram (
        .aclk  (aclk),
        .we    (bram_we),
        .waddr (bram_waddr),
        .wdata (s_data_byte),
        .raddr (bram_raddr),
        .rdata (bram_rdata)
    );

    // Assertions
    `DEDC_ASSERT_ALWAYS(a_clear_after_reset, !aresetn |=> !s_ready, "ready during length clear")
    `DEDC_ASSERT(a_idle_hold_empty, s_ready |-> !hold_valid_reg, "parked byte left between items")
    `DEDC_ASSERT(a_err_on_last, (m_valid && m_error_code != ERR_NONE) |-> m_run_last, "error not on last")
    `DEDC_ASSERT(a_empty_has_err, (m_valid && !m_has_byte) |-> (m_error_code != ERR_NONE), "empty result")
    `DEDC_ASSERT(a_k_in_len, (state_reg == ST_EXPAND) |-> (k_reg < len_reg), "entry byte index past length")

endmodule
